FILE: hdl/dhhp_pkg.sv
// ----------------------------------------------------------------------------
// dhhp_pkg
// Shared types and byte constants for the diff hunk header parser.
// ----------------------------------------------------------------------------
package dhhp_pkg;

    // Width of the signed line fields on the result word.
    localparam int LINE_OUT_W = 25;

    // APB data width.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register index of the edited-side selector.
    localparam logic REG_EDITED_IS_OLD = 1'b0;

    // Byte codes the parser recognises.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Class of one text byte, as decided by the front end.
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DIGIT,
        CLS_NL,
        CLS_COMMA,
        CLS_MODE
    } t_cls;

    // Hunk mode letter.
    typedef enum logic [1:0] {
        MODE_A = 2'd0,
        MODE_C = 2'd1,
        MODE_D = 2'd2
    } t_mode;

    // Kind of mark produced.
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CHANGE = 2'd1,
        KIND_DELETE = 2'd2
    } t_kind;

    // Parse position within a header.
    typedef enum logic [1:0] {
        PH_S1,
        PH_E1,
        PH_S2,
        PH_E2
    } t_phase;

    // One classified word carried from the front end to the back end.
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        t_mode      mode;
        logic       eos;
    } t_qword;

endpackage

FILE: hdl/dhhp_front.sv
// ----------------------------------------------------------------------------
// dhhp_front
// Accepts text bytes and classifies each one into a queue word.
// ----------------------------------------------------------------------------
module dhhp_front (
    input  logic            i_valid,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_stream,
    input  logic            i_full,
    output logic            o_push,
    output dhhp_pkg::t_qword o_word
);
    import dhhp_pkg::*;

    logic [7:0] digit_off;

    // A byte is taken whenever the queue has room.
    assign o_push    = i_valid && !i_full;
    assign digit_off = i_text_byte - CH_0;

    // Classify the byte; the class, digit value, mode letter and end-of-stream flag travel on.
    always_comb begin
        o_word.cls   = CLS_OTHER;
        o_word.digit = 4'd0;
        o_word.mode  = MODE_A;
        o_word.eos   = i_end_of_stream;
        if (i_text_byte >= CH_0 && i_text_byte <= CH_9) begin
            o_word.cls   = CLS_DIGIT;
            o_word.digit = digit_off[3:0];
        end else begin
            unique case (i_text_byte)
                CH_LF, CH_CR: begin
                    o_word.cls = CLS_NL;
                end
                CH_COMMA: begin
                    o_word.cls = CLS_COMMA;
                end
                CH_A: begin
                    o_word.cls  = CLS_MODE;
                    o_word.mode = MODE_A;
                end
                CH_C: begin
                    o_word.cls  = CLS_MODE;
                    o_word.mode = MODE_C;
                end
                CH_D: begin
                    o_word.cls  = CLS_MODE;
                    o_word.mode = MODE_D;
                end
                default: begin
                    o_word.cls = CLS_OTHER;
                end
            endcase
        end
    end

endmodule

FILE: hdl/dhhp_queue.sv
// ----------------------------------------------------------------------------
// dhhp_queue
// Two-word queue between the classifying front end and the parsing back end.
// ----------------------------------------------------------------------------
module dhhp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dhhp_pkg::t_qword i_word,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output dhhp_pkg::t_qword o_word
);
    import dhhp_pkg::*;

    localparam int DEPTH = 2;

    t_qword     r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];

    // Occupancy follows push and pop together.
    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Word storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'(DEPTH)))
        else $error("word pushed into a full queue");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

FILE: hdl/dhhp_back.sv
// ----------------------------------------------------------------------------
// dhhp_back
// Runs the header parser on classified words and registers each mark.
// ----------------------------------------------------------------------------
module dhhp_back #(
    parameter int LINE_WIDTH     = 24,
    parameter int MAX_HEADER_LEN = 99
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_edited_is_old,
    input  logic                                  i_q_valid,
    input  dhhp_pkg::t_qword                      i_q_word,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_mark_kind,
    output logic signed [dhhp_pkg::LINE_OUT_W-1:0] o_first_line,
    output logic signed [dhhp_pkg::LINE_OUT_W-1:0] o_last_line
);
    import dhhp_pkg::*;

    localparam int LEN_W = $clog2(MAX_HEADER_LEN + 1);
    localparam int EXT_W = (LINE_WIDTH > LINE_OUT_W) ? LINE_WIDTH : LINE_OUT_W;

    // Parser state.
    logic                  r_at_head,       n_at_head;
    logic                  r_in_header,     n_in_header;
    logic [LEN_W-1:0]      r_len,           n_len;
    t_phase                r_phase,         n_phase;
    logic                  r_failed,        n_failed;
    t_mode                 r_mode,          n_mode;
    logic [LINE_WIDTH-1:0] r_old_start,     n_old_start;
    logic [LINE_WIDTH-1:0] r_old_end,       n_old_end;
    logic                  r_old_end_given, n_old_end_given;
    logic [LINE_WIDTH-1:0] r_new_start,     n_new_start;
    logic [LINE_WIDTH-1:0] r_new_end,       n_new_end;
    logic                  r_new_end_given, n_new_end_given;

    // Result register.
    logic                  r_out_valid;
    t_kind                 r_kind;
    logic [LINE_OUT_W-1:0] r_first;
    logic [LINE_OUT_W-1:0] r_last;

    logic                  out_free;
    logic                  fire;
    t_kind                 fin_kind;
    logic [LINE_OUT_W-1:0] fin_first;
    logic [LINE_OUT_W-1:0] fin_last;
    logic [LINE_WIDTH-1:0] acc_in;
    logic [LINE_WIDTH-1:0] acc_out;

    // Decimal accumulate with saturation at the line width.
    function automatic logic [LINE_WIDTH-1:0] add_digit(
        input logic [LINE_WIDTH-1:0] cur,
        input logic [3:0]            d
    );
        logic [LINE_WIDTH+3:0] prod;
        prod = ((LINE_WIDTH + 4)'(cur) << 3) + ((LINE_WIDTH + 4)'(cur) << 1)
             + (LINE_WIDTH + 4)'(d);
        if (prod[LINE_WIDTH+3:LINE_WIDTH] != 4'd0) begin
            return '1;
        end
        return prod[LINE_WIDTH-1:0];
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && out_free;

    // The one number being built in the current phase goes through a shared adder.
    always_comb begin
        unique case (r_phase)
            PH_S1:   acc_in = r_old_start;
            PH_E1:   acc_in = r_old_end;
            PH_S2:   acc_in = r_new_start;
            PH_E2:   acc_in = r_new_end;
            default: acc_in = r_new_end;
        endcase
        acc_out = add_digit(acc_in, i_q_word.digit);
    end

    // Next parser state and the mark for a finished header.
    always_comb begin
        logic [EXT_W-1:0] s_ext;
        logic [EXT_W-1:0] e_ext;
        logic             off;
        logic             nl_fire;

        n_at_head       = r_at_head;
        n_in_header     = r_in_header;
        n_len           = r_len;
        n_phase         = r_phase;
        n_failed        = r_failed;
        n_mode          = r_mode;
        n_old_start     = r_old_start;
        n_old_end       = r_old_end;
        n_old_end_given = r_old_end_given;
        n_new_start     = r_new_start;
        n_new_end       = r_new_end;
        n_new_end_given = r_new_end_given;
        nl_fire         = 1'b0;

        // Line head, line end, or one byte of a header.
        if (r_at_head) begin
            if (i_q_word.cls != CLS_NL) begin
                n_at_head = 1'b0;
                if (i_q_word.cls == CLS_DIGIT) begin
                    n_in_header     = 1'b1;
                    n_len           = LEN_W'(1);
                    n_phase         = PH_S1;
                    n_failed        = 1'b0;
                    n_mode          = MODE_A;
                    n_old_start     = LINE_WIDTH'(i_q_word.digit);
                    n_old_end       = '0;
                    n_new_start     = '0;
                    n_new_end       = '0;
                    n_old_end_given = 1'b0;
                    n_new_end_given = 1'b0;
                end
            end
        end else if (i_q_word.cls == CLS_NL) begin
            nl_fire     = r_in_header;
            n_in_header = 1'b0;
            n_len       = '0;
            n_at_head   = 1'b1;
        end else if (r_in_header) begin
            if (!r_failed) begin
                unique case (r_phase)
                    PH_S1: begin
                        if (i_q_word.cls == CLS_COMMA) begin
                            n_old_end_given = 1'b1;
                            n_phase         = PH_E1;
                        end else if (i_q_word.cls == CLS_MODE) begin
                            n_mode  = i_q_word.mode;
                            n_phase = PH_S2;
                        end else if (i_q_word.cls == CLS_DIGIT) begin
                            n_old_start = acc_out;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_E1: begin
                        if (i_q_word.cls == CLS_MODE) begin
                            n_mode  = i_q_word.mode;
                            n_phase = PH_S2;
                        end else if (i_q_word.cls == CLS_DIGIT) begin
                            n_old_end = acc_out;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_S2: begin
                        if (i_q_word.cls == CLS_COMMA) begin
                            n_new_end_given = 1'b1;
                            n_phase         = PH_E2;
                        end else if (i_q_word.cls == CLS_DIGIT) begin
                            n_new_start = acc_out;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_E2: begin
                        if (i_q_word.cls == CLS_DIGIT) begin
                            n_new_end = acc_out;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end
            n_len = r_len + LEN_W'(1);
            if (n_len >= LEN_W'(MAX_HEADER_LEN)) begin
                n_len       = '0;
                n_in_header = 1'b0;
            end
        end

        // Mark from the state as it stands after this byte.
        if (i_edited_is_old) begin
            s_ext = EXT_W'(n_old_start);
            e_ext = n_old_end_given ? EXT_W'(n_old_end) : EXT_W'(n_old_start);
            unique case (n_mode)
                MODE_A:  fin_kind = KIND_DELETE;
                MODE_C:  fin_kind = KIND_CHANGE;
                default: fin_kind = KIND_APPEND;
            endcase
            off = (n_mode != MODE_A);
        end else begin
            s_ext = EXT_W'(n_new_start);
            e_ext = n_new_end_given ? EXT_W'(n_new_end) : EXT_W'(n_new_start);
            unique case (n_mode)
                MODE_A:  fin_kind = KIND_APPEND;
                MODE_C:  fin_kind = KIND_CHANGE;
                default: fin_kind = KIND_DELETE;
            endcase
            off = (n_mode != MODE_D);
        end
        fin_first = s_ext[LINE_OUT_W-1:0] - LINE_OUT_W'(off);
        fin_last  = e_ext[LINE_OUT_W-1:0] - LINE_OUT_W'(off);
        fire      = (nl_fire || (i_q_word.eos && n_in_header))
                    && !n_failed && (n_phase == PH_S2 || n_phase == PH_E2);

        // End of stream returns the parser to the line head.
        if (i_q_word.eos) begin
            n_at_head       = 1'b1;
            n_in_header     = 1'b0;
            n_len           = '0;
            n_phase         = PH_S1;
            n_failed        = 1'b0;
            n_mode          = MODE_A;
            n_old_start     = '0;
            n_old_end       = '0;
            n_new_start     = '0;
            n_new_end       = '0;
            n_old_end_given = 1'b0;
            n_new_end_given = 1'b0;
        end
    end

    // Parser registers advance on every word taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_head       <= 1'b1;
            r_in_header     <= 1'b0;
            r_len           <= '0;
            r_phase         <= PH_S1;
            r_failed        <= 1'b0;
            r_mode          <= MODE_A;
            r_old_start     <= '0;
            r_old_end       <= '0;
            r_old_end_given <= 1'b0;
            r_new_start     <= '0;
            r_new_end       <= '0;
            r_new_end_given <= 1'b0;
        end else if (o_pop) begin
            r_at_head       <= n_at_head;
            r_in_header     <= n_in_header;
            r_len           <= n_len;
            r_phase         <= n_phase;
            r_failed        <= n_failed;
            r_mode          <= n_mode;
            r_old_start     <= n_old_start;
            r_old_end       <= n_old_end;
            r_old_end_given <= n_old_end_given;
            r_new_start     <= n_new_start;
            r_new_end       <= n_new_end;
            r_new_end_given <= n_new_end_given;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && fire;
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (o_pop && fire) begin
            r_kind  <= fin_kind;
            r_first <= fin_first;
            r_last  <= fin_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mark_kind  = r_kind;
    assign o_first_line = r_first;
    assign o_last_line  = r_last;

    a_header_not_at_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> !r_at_head)
        else $error("header open while at line head");

    a_header_len_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> (r_len != '0 && r_len < LEN_W'(MAX_HEADER_LEN)))
        else $error("header length outside its range");

    a_mark_needs_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_pop))
        else $error("mark raised without a word taken");

endmodule

FILE: hdl/diff_hunk_header_parser_core.sv
// ----------------------------------------------------------------------------
// diff_hunk_header_parser_core
// Parses normal-format diff hunk headers from a byte stream into marks.
//
//   Channel  Handshake                  Word
//   -------  -------------------------  --------------------------------------
//   in       i_in_valid / o_in_stall    i_text_byte, i_end_of_stream
//   out      o_out_valid / i_out_stall  o_mark_kind, o_first_line, o_last_line
//   cfg      APB psel/penable/pready    edited_is_old at byte address 0
//
// One byte is taken per cycle while no mark is stalled at the output; the parser
// updates its small registers and the shared decimal accumulator once per byte.
// A mark is registered once its closing byte leaves the queue for the parser.
// A two-word queue parts the classifier from the parser, so it takes up to
// two more bytes while a mark is stalled, then o_in_stall rises.
// Reset is synchronous and active low; it clears the parser and sets
// edited_is_old to 0. There is no clearing pass.
// ----------------------------------------------------------------------------
module diff_hunk_header_parser_core #(
    parameter int LINE_WIDTH     = 24,
    parameter int MAX_HEADER_LEN = 99
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Text input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [7:0]                             i_text_byte,
    input  logic                                   i_end_of_stream,
    // Mark output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_mark_kind,
    output logic signed [dhhp_pkg::LINE_OUT_W-1:0] o_first_line,
    output logic signed [dhhp_pkg::LINE_OUT_W-1:0] o_last_line,
    // Configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dhhp_pkg::APB_AW-1:0]            paddr,
    input  logic [dhhp_pkg::APB_DW-1:0]            pwdata,
    output logic [dhhp_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import dhhp_pkg::*;

    logic   r_edited_is_old;
    logic   q_full;
    logic   q_push;
    logic   q_valid;
    logic   q_pop;
    t_qword front_word;
    t_qword q_word;

    // Configuration register; word index taken from the upper address bit.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edited_is_old <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_EDITED_IS_OLD) begin
            r_edited_is_old <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_EDITED_IS_OLD) begin
            prdata[0] = r_edited_is_old;
        end
    end

    assign o_in_stall = q_full;

    dhhp_front u_front (
        .i_valid         (i_in_valid),
        .i_text_byte     (i_text_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_word          (front_word)
    );

    dhhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    dhhp_back #(
        .LINE_WIDTH     (LINE_WIDTH),
        .MAX_HEADER_LEN (MAX_HEADER_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_edited_is_old (r_edited_is_old),
        .i_q_valid       (q_valid),
        .i_q_word        (q_word),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mark_kind     (o_mark_kind),
        .o_first_line    (o_first_line),
        .o_last_line     (o_last_line)
    );

endmodule
